@@ src/lcbb_pkg.sv @@
// lcbb_pkg: types and constants for the byte-budget lru cache table
// used by lru_cache_byte_budget_unit; no dependencies
`timescale 1ns / 1ps
package lcbb_pkg;
  localparam int ENTRIES_DEF     = 16;
  localparam int TAG_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int SIZE_BITS_DEF   = 24;

  localparam logic       OP_LOOKUP  = 1'b0;
  localparam logic       OP_INSERT  = 1'b1;
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_EVICT  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef struct packed {
    logic                       operation;
    logic [TAG_BITS_DEF-1:0]    key_tag;
    logic [HANDLE_BITS_DEF-1:0] entry_handle;
    logic [SIZE_BITS_DEF-1:0]   entry_bytes;
  } lcbb_in_t;

  typedef struct packed {
    logic [1:0]                 kind;
    logic                       hit;
    logic [HANDLE_BITS_DEF-1:0] handle_out;
    logic [TAG_BITS_DEF-1:0]    key_out;
    logic [SIZE_BITS_DEF-1:0]   bytes_out;
    logic                       last;
  } lcbb_out_t;
endpackage

@@ src/lru_cache_byte_budget_unit.sv @@
// lru cache table under a byte budget: lookup, insert, eviction notices
// order: a same-key entry is dropped before the insert; trim evictions follow it, one notice each
// throughput: one item at a time; in_stall stays high until the item is done, and out_stall can delay it
// reset: rst_n synchronous; valid bits, age ranks, used bytes, budget and output clear at once
`timescale 1ns / 1ps
module lru_cache_byte_budget_unit
  import lcbb_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lcbb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lcbb_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [SIZE_BITS_DEF-1:0] cfg_data
);
  localparam int IW = $clog2(ENTRIES);
  localparam int TW = TAG_BITS_DEF;
  localparam int HW = HANDLE_BITS_DEF;
  localparam int SW = SIZE_BITS_DEF;
  localparam int PW = TW + HW + SW;
  localparam int UW = SW + IW + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_FIND = 3'd1, S_LKUP = 3'd2,
                         S_EVRD = 3'd3, S_DROP = 3'd4, S_DONE = 3'd5;

  // payload memory: tag, handle, size
  logic [PW-1:0] mem [ENTRIES];
  logic [PW-1:0] rd_q;
  logic         wr_en;
  logic [IW-1:0] wr_a, rd_a;
  logic [PW-1:0] wr_d;
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rd_q <= mem[rd_a];
  end

  // tag copy for parallel compare (per-slot flops)
  logic [TW-1:0] tagc_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0] rank_r [ENTRIES];
  logic [IW-1:0] rank_nxt [ENTRIES];
  logic [UW-1:0] used_r, used_nxt;
  logic [SW-1:0] cap_r;
  logic [2:0] st_r, st_nxt;
  lcbb_in_t item_r;
  logic [IW-1:0] slot_r, slot_nxt;
  logic hit_r, hit_nxt, ev_any_r, ev_any_nxt;
  lcbb_out_t obuf_r, obuf_nxt;
  logic ov_r, ov_nxt;

  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = obuf_r;

  // fields of the slot read last cycle
  logic [TW-1:0] rd_tag;
  logic [HW-1:0] rd_handle;
  logic [SW-1:0] rd_bytes;
  logic [UW-1:0] used_less, used_swap;
  assign rd_tag    = rd_q[PW-1 -: TW];
  assign rd_handle = rd_q[SW +: HW];
  assign rd_bytes  = rd_q[SW-1:0];
  assign used_less = used_r - UW'(rd_bytes);
  assign used_swap = used_less + UW'(item_r.entry_bytes);

  // tag match, first free slot and oldest search over the slots
  logic [ENTRIES-1:0] match;
  logic [IW-1:0] match_i, old_i, free_i, maxr;
  logic any_match, any_free, any_valid;
  always_comb begin
    match_i = '0; any_match = 1'b0; free_i = '0; any_free = 1'b0;
    old_i = '0; any_valid = 1'b0; maxr = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (tagc_r[i] == item_r.key_tag);
      if (match[i] && !any_match) begin
        any_match = 1'b1; match_i = IW'(i);
      end
      if (!valid_r[i] && !any_free) begin
        any_free = 1'b1; free_i = IW'(i);
      end
      if (valid_r[i] && (!any_valid || rank_r[i] > maxr)) begin
        any_valid = 1'b1; old_i = IW'(i); maxr = rank_r[i];
      end
    end
  end

  wire out_free = !ov_r || !out_stall;

  always_comb begin
    st_nxt = st_r; valid_nxt = valid_r; used_nxt = used_r; slot_nxt = slot_r;
    hit_nxt = hit_r; ev_any_nxt = ev_any_r; obuf_nxt = obuf_r;
    ov_nxt = ov_r && out_stall;
    wr_en = 1'b0; wr_a = slot_r; rd_a = slot_r;
    wr_d = {item_r.key_tag, item_r.entry_handle, item_r.entry_bytes};
    for (int i = 0; i < ENTRIES; i++) rank_nxt[i] = rank_r[i];
    case (st_r)
      S_IDLE: begin
        if (in_valid) st_nxt = S_FIND;
      end
      S_FIND: begin
        if (item_r.operation == OP_LOOKUP) begin
          hit_nxt = any_match; slot_nxt = match_i; rd_a = match_i;
          if (any_match) begin
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] < rank_r[match_i])
                rank_nxt[i] = rank_r[i] + 1'b1;
            rank_nxt[match_i] = '0;
          end
          st_nxt = S_LKUP;
        end else begin
          ev_any_nxt = 1'b0;
          hit_nxt = 1'b0;
          if (any_match) begin
            // same key: read its size first, then drop it silently
            slot_nxt = match_i; rd_a = match_i; st_nxt = S_DROP;
          end else if (any_free) begin
            slot_nxt = free_i;
            st_nxt = S_DONE;
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i]) rank_nxt[i] = rank_r[i] + 1'b1;
            rank_nxt[free_i] = '0;
            valid_nxt[free_i] = 1'b1;
            wr_en = 1'b1; wr_a = free_i;
            used_nxt = used_r + UW'(item_r.entry_bytes);
          end else begin
            // full: evict oldest, its slot then takes the new entry
            slot_nxt = old_i; rd_a = old_i; hit_nxt = 1'b1; st_nxt = S_EVRD;
          end
        end
      end
      S_LKUP: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          obuf_nxt = '{kind: KIND_LOOKUP, hit: hit_r,
                       handle_out: hit_r ? rd_handle : '0,
                       key_out: '0, bytes_out: '0, last: 1'b1};
          st_nxt = S_IDLE;
        end
      end
      S_DROP: begin
        // slot_r gives up the old entry and holds the new one as most recent
        for (int i = 0; i < ENTRIES; i++)
          if (valid_r[i] && i != int'(slot_r)) rank_nxt[i] =
            ((rank_r[i] > rank_r[slot_r]) ? rank_r[i] - 1'b1 : rank_r[i]) + 1'b1;
        rank_nxt[slot_r] = '0;
        wr_en = 1'b1;
        used_nxt = used_swap;
        st_nxt = S_DONE;
      end
      S_EVRD: begin
        // rd_q holds the oldest slot; last is known from the bytes left
        if (out_free) begin
          ov_nxt = 1'b1;
          ev_any_nxt = 1'b1;
          st_nxt = S_DONE;
          if (hit_r) begin
            hit_nxt = 1'b0;
            obuf_nxt = '{kind: KIND_EVICT, hit: 1'b0, handle_out: rd_handle,
                         key_out: rd_tag, bytes_out: rd_bytes,
                         last: (used_swap <= UW'(cap_r))};
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && i != int'(slot_r)) rank_nxt[i] =
                ((rank_r[i] > rank_r[slot_r]) ? rank_r[i] - 1'b1 : rank_r[i]) + 1'b1;
            rank_nxt[slot_r] = '0;
            wr_en = 1'b1;
            used_nxt = used_swap;
          end else begin
            obuf_nxt = '{kind: KIND_EVICT, hit: 1'b0, handle_out: rd_handle,
                         key_out: rd_tag, bytes_out: rd_bytes,
                         last: (used_less <= UW'(cap_r))};
            for (int i = 0; i < ENTRIES; i++)
              if (valid_r[i] && rank_r[i] > rank_r[slot_r])
                rank_nxt[i] = rank_r[i] - 1'b1;
            valid_nxt[slot_r] = 1'b0;
            used_nxt = used_less;
          end
        end
      end
      S_DONE: begin
        if (used_r > UW'(cap_r) && any_valid) begin
          slot_nxt = old_i; rd_a = old_i; st_nxt = S_EVRD;
        end else if (ev_any_r) begin
          // the final notice already went out with last set
          st_nxt = S_IDLE;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          obuf_nxt = '{kind: KIND_DONE, hit: 1'b0, handle_out: '0, key_out: '0,
                       bytes_out: '0, last: 1'b1};
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; valid_r <= '0; used_r <= '0; cap_r <= '0;
      ov_r <= 1'b0; obuf_r <= '0; ev_any_r <= 1'b0; hit_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= '0;
    end else begin
      st_r <= st_nxt; valid_r <= valid_nxt; used_r <= used_nxt;
      hit_r <= hit_nxt; ev_any_r <= ev_any_nxt;
      ov_r <= ov_nxt; obuf_r <= obuf_nxt;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= rank_nxt[i];
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) item_r <= in_data;
    slot_r <= slot_nxt;
    if (wr_en) tagc_r[wr_a] <= item_r.key_tag;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (st_r == S_IDLE)) else $error("cfg while busy");
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LKUP && out_free) |=> (st_r == S_IDLE)) else $error("lookup stuck");
  a_used_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r == '0) |-> (used_r == '0)) else $error("used bytes leak");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(obuf_r))) else $error("result dropped");
`endif
endmodule

@@ sim/tb_lru_cache_byte_budget_unit.sv @@
// testbench for lru_cache_byte_budget_unit: lookups, inserts and evictions checked
// against an in-bench lru table predictor; depends on lcbb_pkg and the unit
`timescale 1ns / 1ps
module tb_lru_cache_byte_budget_unit
  import lcbb_pkg::*;
();

  localparam int NSLOT = ENTRIES_DEF;
  localparam int EXPQ  = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  lcbb_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  lcbb_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  lru_cache_byte_budget_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor copy of the table
  logic        pv [NSLOT];
  logic [63:0] ptag [NSLOT];
  logic [31:0] phandle [NSLOT];
  logic [23:0] pbytes [NSLOT];
  int          prank [NSLOT];
  logic [28:0] pused;
  logic [23:0] pbudget;

  // expected results, ring of items not yet seen
  lcbb_out_t exp_q [EXPQ];
  int        exp_wr;
  int        exp_rd;
  int        err_count;
  logic      rx_stall_en;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_lru_cache_byte_budget_unit: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  function automatic void queue_result(lcbb_out_t r);
    exp_q[exp_wr % EXPQ] = r;
    exp_wr++;
  endfunction

  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < NSLOT; i++) if (pv[i] && ptag[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_oldest_slot();
    int b;
    b = -1;
    for (int i = 0; i < NSLOT; i++)
      if (pv[i] && (b < 0 || prank[i] > prank[b])) b = i;
    return b;
  endfunction

  function automatic void drop_entry(int s);
    for (int j = 0; j < NSLOT; j++) if (pv[j] && prank[j] > prank[s]) prank[j]--;
    pv[s] = 1'b0;
    pused = pused - 29'(pbytes[s]);
  endfunction

  function automatic void evict_entry(inout int n);
    int s;
    lcbb_out_t r;
    s = find_oldest_slot();
    if (s < 0) return;
    r = '0;
    r.kind = KIND_EVICT;
    r.handle_out = phandle[s];
    r.key_out = ptag[s];
    r.bytes_out = pbytes[s];
    queue_result(r);
    n++;
    drop_entry(s);
  endfunction

  function automatic void predict_table(lcbb_in_t it);
    int s, fs, n;
    lcbb_out_t r;
    r = '0;
    n = 0;
    fs = -1;
    s = find_key(it.key_tag);
    if (it.operation == OP_LOOKUP) begin
      r.kind = KIND_LOOKUP;
      r.last = 1'b1;
      if (s >= 0) begin
        for (int j = 0; j < NSLOT; j++) if (pv[j] && prank[j] < prank[s]) prank[j]++;
        prank[s] = 0;
        r.hit = 1'b1;
        r.handle_out = phandle[s];
      end
      queue_result(r);
      return;
    end
    if (s >= 0) drop_entry(s);
    for (int j = 0; j < NSLOT; j++) if (!pv[j] && fs < 0) fs = j;
    if (fs < 0) begin
      fs = find_oldest_slot();
      evict_entry(n);
    end
    for (int j = 0; j < NSLOT; j++) if (pv[j]) prank[j]++;
    pv[fs] = 1'b1;
    prank[fs] = 0;
    ptag[fs] = it.key_tag;
    phandle[fs] = it.entry_handle;
    pbytes[fs] = it.entry_bytes;
    pused = pused + 29'(it.entry_bytes);
    for (int j = 0; j < NSLOT && pused > 29'(pbudget); j++) evict_entry(n);
    if (n == 0) begin
      r.kind = KIND_DONE;
      r.last = 1'b1;
      queue_result(r);
    end else begin
      exp_q[(exp_wr - 1) % EXPQ].last = 1'b1;
    end
  endfunction

  // result checker and receiver stall
  initial begin
    int gap;
    lcbb_out_t w;
    out_stall = 1'b1;
    gap = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected result", out_data.key_out, 64'd0);
        end else begin
          w = exp_q[exp_rd % EXPQ];
          exp_rd++;
          if (out_data.kind !== w.kind)
            report_mismatch("kind", 64'(out_data.kind), 64'(w.kind));
          if (out_data.hit !== w.hit)
            report_mismatch("hit", 64'(out_data.hit), 64'(w.hit));
          if (out_data.handle_out !== w.handle_out)
            report_mismatch("handle", 64'(out_data.handle_out), 64'(w.handle_out));
          if (out_data.key_out !== w.key_out)
            report_mismatch("key", out_data.key_out, w.key_out);
          if (out_data.bytes_out !== w.bytes_out)
            report_mismatch("bytes", 64'(out_data.bytes_out), 64'(w.bytes_out));
          if (out_data.last !== w.last)
            report_mismatch("last", 64'(out_data.last), 64'(w.last));
        end
        gap = rx_stall_en ? $urandom_range(0, 17) : 0;
      end
      if (!rst_n) out_stall <= 1'b1;
      else if (gap > 0) begin
        out_stall <= 1'b1;
        gap--;
      end else out_stall <= 1'b0;
    end
  end

  // valid stays up between back to back items and drops only for a gap
  task automatic send_item(input logic op, input logic [63:0] k, input logic [31:0] h,
                           input logic [23:0] b, input bit do_gap);
    lcbb_in_t it;
    int g;
    it.operation = op;
    it.key_tag = k;
    it.entry_handle = h;
    it.entry_bytes = b;
    g = do_gap ? $urandom_range(0, 17) : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_table(it);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_budget(input logic [23:0] v);
    drain_all();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pbudget = v;
  endtask

  task automatic test_directed();
    write_budget(24'hFFFFFF);
    send_item(OP_LOOKUP, 64'h0, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0);
    send_item(OP_INSERT, 64'h0, 32'h0, 24'h0, 1'b0);
    send_item(OP_INSERT, 64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b0);
    send_item(OP_LOOKUP, 64'hFFFFFFFFFFFFFFFF, 32'h0, 24'h0, 1'b0);
    send_item(OP_LOOKUP, 64'h0, 32'h0, 24'h0, 1'b0);
    // same key again replaces silently, then pushes over budget and evicts the oldest
    send_item(OP_INSERT, 64'h0, 32'h1234, 24'h10, 1'b0);
    // fits within the budget, no eviction
    send_item(OP_INSERT, 64'h55, 32'h5, 24'h1, 1'b0);
    // fill the table then overflow it
    for (int i = 0; i < 17; i++)
      send_item(OP_INSERT, 64'h100 + 64'(i), 32'(i), 24'h0, 1'b0);
    send_item(OP_LOOKUP, 64'h105, 32'h0, 24'h0, 1'b0);
    // zero budget: a nonzero size evicts every entry, itself last; zero size kept
    write_budget(24'h0);
    send_item(OP_INSERT, 64'h200, 32'h7, 24'h1, 1'b0);
    send_item(OP_INSERT, 64'h201, 32'h8, 24'h0, 1'b0);
  endtask

  task automatic test_random(input int count, input logic [23:0] max_sz);
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 23));
      send_item(1'($urandom_range(0, 1)), k, $urandom,
                24'($urandom_range(0, max_sz)), 1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    err_count = 0;
    exp_wr = 0;
    exp_rd = 0;
    rx_stall_en = 1'b1;
    pused = '0;
    pbudget = '0;
    for (int i = 0; i < NSLOT; i++) begin
      pv[i] = 1'b0;
      prank[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_budget(24'd400);
    test_random(120, 24'd100);
    // sender holds off until every result is back
    drain_all();
    write_budget(24'd40);
    rx_stall_en = 1'b0;
    test_random(60, 24'd30);
    rx_stall_en = 1'b1;
    write_budget(24'hFFFFFF);
    test_random(100, 24'hFFFFFF);
    write_budget(24'h800000);
    test_random(110, 24'hFFFFFF);
    drain_all();
    if (err_count == 0) $display("tb_lru_cache_byte_budget_unit: PASS");
    else $display("tb_lru_cache_byte_budget_unit: FAIL");
    $finish;
  end
endmodule
